@@ src/fdwq_pkg.sv @@
// shared types and constants of the fifo or deadline wait queue
package fdwq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 8;
    localparam int PRI_W  = 32;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic [0:0] MODE_INSERT = 1'b0;
    localparam logic [0:0] MODE_POP    = 1'b1;

    localparam logic [0:0] POL_FIFO = 1'b0;
    localparam logic [0:0] POL_EDF  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [IDX_W-1:0] REG_ORDER_POLICY = 2'd0;
    localparam logic [IDX_W-1:0] REG_BURNOUT      = 2'd1;

    typedef struct packed {
        logic [0:0]      mode;
        logic [ID_W-1:0] requester_id;
        logic [PRI_W-1:0] last_compile_ms;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   popped_id;
        logic [PRI_W-1:0]  popped_priority;
        logic [OCC_W-1:0]  occupancy;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

@@ src/fdwq_ram.sv @@
// generic single write port, single read port ram with registered read
module fdwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fifo_or_deadline_wait_queue.sv @@
// top level of the fifo or deadline wait queue
//
// A request is taken at a clock edge with start high and busy low. Mode
// insert stores requester_id with the deadline last_compile_ms + burnout_ms
// (saturated); mode pop removes the head. Each request gives exactly one
// result on o_res, marked by o_done for one cycle; the receiver cannot
// stall, so results are never held.
// Entries live in one ram used as a ring buffer behind a head pointer; a
// small sequencer walks it one entry per step.
// Fifo inserts, inserts into an empty queue, rejected inserts and pops on
// an empty queue are answered from idle; a pop reads the head, then answers
// from S_POP_OUT. A deadline insert reads and compares the entries from the
// head through the one ram read port; if it lands ahead of an entry, the later
// entries move up one slot each before it is written, else it goes at the tail.
// busy stays high until the result is out; the next request may start in
// the cycle o_done is high.
// Configuration writes (order_policy, burnout_ms) take effect at once and
// are to be made only while idle; the block itself does not enforce it.
// Reset empties the queue, sets fifo order and a zero budget; ram contents
// are left as they are.
module fifo_or_deadline_wait_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fdwq_pkg::t_req            i_req,
    output logic                      o_done,
    output fdwq_pkg::t_res            o_res,
    input  logic                      i_cfg_we,
    input  logic [fdwq_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [fdwq_pkg::CFG_W-1:0] i_cfg_data
);
    import fdwq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_SHIFT_RD = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_INS_WR   = 3'd5;
    localparam logic [2:0] S_POP_OUT  = 3'd6;

    function automatic logic [PTR_W-1:0] f_phys(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [ID_W-1:0]  r_id, n_id;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic [0:0]       r_policy;
    logic [PRI_W-1:0] r_burnout;
    logic             r_done, n_done;
    t_res             r_res, n_res;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PTR_W-1:0] ram_raddr;
    t_slot            ram_wdata;
    t_slot            ram_rdata;
    logic [PRI_W:0]   dl_sum;
    logic [PRI_W-1:0] dl_sat;

    // saturating deadline
    assign dl_sum = {1'b0, i_req.last_compile_ms} + {1'b0, r_burnout};
    assign dl_sat = dl_sum[PRI_W] ? {PRI_W{1'b1}} : dl_sum[PRI_W-1:0];

    always_comb begin
        case (r_state)
            S_SCAN_RD:  ram_raddr = f_phys(r_head, r_k);
            S_SHIFT_RD: ram_raddr = f_phys(r_head, r_k - CNT_W'(1));
            default:    ram_raddr = r_head;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_k       = r_k;
        n_pos     = r_pos;
        n_id      = r_id;
        n_pri     = r_pri;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = f_phys(r_head, r_pos);
        ram_wdata = '{id: r_id, pri: r_pri};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id  = i_req.requester_id;
                    n_pri = dl_sat;
                    n_res = '0;
                    if (i_req.mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_done           = 1'b1;
                            n_res.status     = ST_EMPTY;
                            n_res.occupancy  = OCC_W'(r_count);
                        end else begin
                            n_state = S_POP_OUT;
                        end
                    end else if (r_count == CNT_W'(DEPTH)) begin
                        n_done          = 1'b1;
                        n_res.status    = ST_FULL;
                        n_res.occupancy = OCC_W'(r_count);
                    end else if (r_policy == POL_FIFO || r_count == '0) begin
                        ram_we          = 1'b1;
                        ram_waddr       = f_phys(r_head, r_count);
                        ram_wdata       = '{id: i_req.requester_id, pri: dl_sat};
                        n_count         = r_count + CNT_W'(1);
                        n_done          = 1'b1;
                        n_res.status    = ST_OK;
                        n_res.occupancy = OCC_W'(r_count + CNT_W'(1));
                    end else begin
                        n_k     = '0;
                        n_state = S_SCAN_CMP;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (ram_rdata.pri > r_pri) begin
                    n_pos   = r_k;
                    n_k     = r_count;
                    n_state = S_SHIFT_RD;
                end else if (r_k + CNT_W'(1) == r_count) begin
                    n_pos   = r_count;
                    n_state = S_INS_WR;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = f_phys(r_head, r_k);
                ram_wdata = ram_rdata;
                n_k       = r_k - CNT_W'(1);
                n_state   = (r_k - CNT_W'(1) == r_pos) ? S_INS_WR : S_SHIFT_RD;
            end
            S_INS_WR: begin
                ram_we          = 1'b1;
                n_count         = r_count + CNT_W'(1);
                n_done          = 1'b1;
                n_res.status    = ST_OK;
                n_res.occupancy = OCC_W'(r_count + CNT_W'(1));
                n_state         = S_IDLE;
            end
            S_POP_OUT: begin
                n_head                = f_phys(r_head, CNT_W'(1));
                n_count               = r_count - CNT_W'(1);
                n_done                = 1'b1;
                n_res.status          = ST_OK;
                n_res.popped_id       = ram_rdata.id;
                n_res.popped_priority = (r_policy == POL_EDF) ? ram_rdata.pri : '0;
                n_res.occupancy       = OCC_W'(r_count - CNT_W'(1));
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_policy  <= POL_FIFO;
            r_burnout <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORDER_POLICY: r_policy  <= i_cfg_data[0];
                    REG_BURNOUT:      r_burnout <= i_cfg_data[PRI_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pos <= n_pos;
        r_id  <= n_id;
        r_pri <= n_pri;
        r_res <= n_res;
    end

    fdwq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the fifo or deadline wait queue
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fdwq_pkg::*;

    localparam int SETTLE_CYCLES = 4 * DEPTH + 8;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 100;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_done;
    t_res              o_res;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    logic [0:0]        model_policy;
    logic [PRI_W-1:0]  model_budget;
    t_slot             model_slots[DEPTH];
    int                model_count;

    t_res              expected_results[$];
    int                error_count;
    int                burst_left;
    bit                steady;

    fifo_or_deadline_wait_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [PRI_W-1:0] deadline(input logic [PRI_W-1:0] ms);
        logic [PRI_W:0] sum;
        sum = {1'b0, ms} + {1'b0, model_budget};
        return sum[PRI_W] ? '1 : sum[PRI_W-1:0];
    endfunction

    function automatic t_res queue_step(input t_req req);
        t_res             res;
        logic [PRI_W-1:0] pri;
        int               pos;
        res = '0;
        res.status = ST_OK;
        if (req.mode == MODE_INSERT) begin
            if (model_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pri = deadline(req.last_compile_ms);
                pos = model_count;
                if (model_policy == POL_EDF) begin
                    pos = 0;
                    while (pos < model_count && model_slots[pos].pri <= pri) pos++;
                end
                for (int i = model_count; i > pos; i--) model_slots[i] = model_slots[i-1];
                model_slots[pos].id  = req.requester_id;
                model_slots[pos].pri = pri;
                model_count++;
            end
        end else if (model_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.popped_id       = model_slots[0].id;
            res.popped_priority = (model_policy == POL_EDF) ? model_slots[0].pri : '0;
            for (int i = 1; i < model_count; i++) model_slots[i-1] = model_slots[i];
            model_count--;
        end
        res.occupancy = model_count[OCC_W-1:0];
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [PRI_W-1:0] want,
                                          input logic [PRI_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("status expected none actual %0h", o_res.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", PRI_W'(want.status), PRI_W'(o_res.status));
                compare_field("popped_id", PRI_W'(want.popped_id), PRI_W'(o_res.popped_id));
                compare_field("popped_priority", want.popped_priority, o_res.popped_priority);
                compare_field("occupancy", PRI_W'(want.occupancy), PRI_W'(o_res.occupancy));
            end
        end
    end

    // start stays high across a burst, dropped only when a gap follows
    task automatic send_request(input logic [0:0] mode, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] ms);
        t_req req;
        req.mode            = mode;
        req.requester_id    = id;
        req.last_compile_ms = ms;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(queue_step(req));
        if (!steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 7);
                @(negedge i_clk);
                start <= 1'b0;
                repeat ($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 70))
                    @(negedge i_clk);
            end
        end
    endtask

    task automatic insert(input logic [ID_W-1:0] id, input logic [PRI_W-1:0] ms);
        send_request(MODE_INSERT, id, ms);
    endtask

    task automatic pop();
        send_request(MODE_POP, ID_W'($urandom), $urandom);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_ORDER_POLICY: model_policy = data[0];
            REG_BURNOUT:      model_budget = data;
            default: ;
        endcase
    endtask

    // upper bits of the policy word are noise
    task automatic configure(input logic [0:0] policy, input logic [PRI_W-1:0] budget);
        wait_idle();
        write_config(REG_ORDER_POLICY, {(CFG_W-1)'($urandom), policy});
        write_config(REG_BURNOUT, budget);
    endtask

    task automatic test_fifo_edges();
        configure(POL_FIFO, '0);
        pop();
        insert(8'h00, '0);
        insert(8'hff, '1);
        insert(8'ha5, 32'h5a5a_5a5a);
        repeat (3) pop();
    endtask

    // ties keep arrival order, sums past the top saturate
    task automatic test_deadline_order();
        configure(POL_EDF, 32'hffff_fff0);
        insert(8'h11, 32'd100);
        insert(8'h22, 32'd5);
        insert(8'h33, 32'd5);
        insert(8'h44, 32'd0);
        repeat (4) pop();
    endtask

    task automatic test_order_switch();
        configure(POL_FIFO, 32'd1000);
        insert(8'h01, 32'd50);
        insert(8'h02, 32'd10);
        configure(POL_EDF, 32'd1000);
        insert(8'h03, 32'd30);
        repeat (3) pop();
    endtask

    // each insert lands at the head, then one over the top and one under
    task automatic test_full_queue();
        configure(POL_EDF, '0);
        for (int i = 0; i < DEPTH; i++) insert(ID_W'(i), PRI_W'(DEPTH - i));
        insert(8'h7e, '0);
        repeat (DEPTH + 1) pop();
    endtask

    task automatic test_random_traffic();
        logic [PRI_W-1:0] budget;
        logic [PRI_W-1:0] ms;
        int               insert_pct;
        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       budget = '0;
                1:       budget = '1;
                2:       budget = $urandom_range(0, 100);
                default: budget = $urandom;
            endcase
            configure(phase[0] ^ 1'($urandom_range(0, 1)), budget);
            steady     = ($urandom_range(0, 3) == 0);
            insert_pct = $urandom_range(30, 80);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 3))
                    0:       ms = $urandom;
                    1:       ms = $urandom_range(0, 7);
                    2:       ms = '1 - $urandom_range(0, 15);
                    default: ms = 32'h8000_0000 + $urandom_range(0, 31);
                endcase
                if ($urandom_range(0, 99) < insert_pct) insert(ID_W'($urandom), ms);
                else pop();
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        model_policy = POL_FIFO;
        model_budget = '0;
        model_count  = 0;
        error_count  = 0;
        burst_left   = 0;
        steady       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fifo_edges();
        test_deadline_order();
        test_order_switch();
        test_full_queue();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS fifo_or_deadline_wait_queue");
        end else begin
            $display("FAIL fifo_or_deadline_wait_queue");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL fifo_or_deadline_wait_queue");
        $finish;
    end

endmodule
